/* rtl/core/led_blink_pattern_sequencer_top_macros.svh */
// ---------------------------------------------------------------------------
// LED blink pattern sequencer assertion macros
// Concurrent property wrappers clocked on clk_i, disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef LED_BLINK_PATTERN_SEQUENCER_TOP_MACROS_SVH
`define LED_BLINK_PATTERN_SEQUENCER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define LBPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lbps assertion failed");
`define LBPS_ASSERT_NEVER(lbl, cond) \
  `LBPS_ASSERT(lbl, !(cond))
`else
`define LBPS_ASSERT(lbl, prop)
`define LBPS_ASSERT_NEVER(lbl, cond)
`endif

`endif

/* rtl/core/lbps_pkg.sv */
// ---------------------------------------------------------------------------
// LED blink pattern sequencer package
// Slot record, command codes, mode constants and pattern tables.
// ---------------------------------------------------------------------------
package lbps_pkg;

  localparam int NUM_SLOTS  = 4;
  localparam int MAX_PHASES = 10;
  localparam int SLOT_AW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam logic [3:0] MODE_ON   = 4'd0;
  localparam logic [3:0] MODE_OFF  = 4'd1;
  localparam logic [3:0] NO_MODE   = 4'd15;
  localparam logic [3:0] NUM_MODES = 4'd15;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_SET    = 3'd1,
    CMD_QUERY  = 3'd2,
    CMD_PAUSE  = 3'd3,
    CMD_RESUME = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [7:0] pin;
    logic [3:0] mode;
    logic [3:0] phase;
    logic [6:0] ticks;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // number of phases in a mode's pattern
  function automatic logic [3:0] pat_len(input logic [3:0] mode);
    logic [3:0] n;
    case (mode)
      4'd5, 4'd6, 4'd10, 4'd13: n = 4'd2;
      4'd7, 4'd11, 4'd14:       n = 4'd4;
      4'd8, 4'd12:              n = 4'd6;
      4'd9:                     n = 4'd8;
      4'd15:                    n = 4'd0;
      default:                  n = 4'd1;
    endcase
    return n;
  endfunction

  // duration of the final phase
  function automatic logic [6:0] pat_final(input logic [3:0] mode);
    logic [6:0] d;
    case (mode)
      4'd0:    d = 7'd1;
      4'd1:    d = 7'd0;
      4'd2:    d = 7'd1;
      4'd3:    d = 7'd2;
      4'd4:    d = 7'd4;
      4'd5:    d = 7'd3;
      4'd6:    d = 7'd19;
      4'd7:    d = 7'd15;
      4'd8:    d = 7'd13;
      4'd9:    d = 7'd10;
      4'd10:   d = 7'd39;
      4'd11:   d = 7'd36;
      4'd12:   d = 7'd33;
      4'd13:   d = 7'd59;
      4'd14:   d = 7'd56;
      default: d = 7'd0;
    endcase
    return d;
  endfunction

  // leading phases alternate 1,2; the final phase has its own length
  function automatic logic [6:0] pat_dur(input logic [3:0] mode, input logic [3:0] ph);
    logic [4:0] len;
    logic [6:0] d;
    len = {1'b0, pat_len(mode)};
    if ({1'b0, ph} >= len) begin
      d = 7'd0;
    end else if ({1'b0, ph} == len - 5'd1) begin
      d = pat_final(mode);
    end else begin
      d = ph[0] ? 7'd2 : 7'd1;
    end
    return d;
  endfunction

  function automatic logic [4:0] phase_count(input logic [3:0] mode);
    logic [4:0] n;
    n = {1'b0, pat_len(mode)};
    if (n > 5'(MAX_PHASES)) begin
      n = 5'(MAX_PHASES);
    end
    return n;
  endfunction

endpackage

/* rtl/core/lbps_ram.sv */
// ---------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module lbps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/led_blink_pattern_sequencer_top.sv */
// ---------------------------------------------------------------------------
// LED blink pattern sequencer
// Tick, set mode, query, pause, resume over a RAM-held slot table.
// ---------------------------------------------------------------------------
// Tick, set mode and query go busy while the slot RAM is read one slot per cycle,
// then while the last read data returns and for a finish state; the next request
// is taken once busy drops. Pause, resume and ignored requests never go busy.
// A drive write is held one slot back so the final one carries last; the final
// result is registered out of the finish state. The receiver cannot stall.
// Reset clears slot-in-use flags and sets running; no clearing pass is needed.
`include "led_blink_pattern_sequencer_top_macros.svh"

module led_blink_pattern_sequencer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [2:0] cmd_i,
  input  logic [7:0] pin_id_i,
  input  logic [3:0] new_mode_i,
  output logic       valid_o,
  output logic       kind_o,
  output logic [7:0] out_pin_o,
  output logic       level_o,
  output logic [3:0] reported_mode_o,
  output logic       last_o
);
  import lbps_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_LAST = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [SLOT_AW-1:0]   idx_q, idx_d;
  logic [SLOT_AW-1:0]   pidx_q, pidx_d;
  logic                 rv_q, rv_d;
  logic [2:0]           op_q, op_d;
  logic [7:0]           pin_q, pin_d;
  logic [3:0]           mode_q, mode_d;
  logic [NUM_SLOTS-1:0] used_q, used_d;
  logic                 running_q, running_d;
  logic                 found_q, found_d;
  logic [SLOT_AW-1:0]   fidx_q, fidx_d;
  logic [3:0]           fmode_q, fmode_d;
  logic                 free_q, free_d;
  logic [SLOT_AW-1:0]   freeidx_q, freeidx_d;
  logic                 pend_v_q, pend_v_d;
  logic [7:0]           pend_pin_q, pend_pin_d;
  logic                 pend_lvl_q, pend_lvl_d;
  logic                 valid_q, valid_d;
  logic                 kind_q, kind_d;
  logic [7:0]           opin_q, opin_d;
  logic                 lvl_q, lvl_d;
  logic [3:0]           rmode_q, rmode_d;
  logic                 last_q, last_d;

  logic                 ram_we, ram_re;
  logic [SLOT_AW-1:0]   ram_waddr, ram_raddr;
  slot_t                ram_wdata, rd;
  logic [SLOT_W-1:0]    ram_rdata;

  logic                 new_v, new_lvl;
  logic [7:0]           new_pin;
  logic [6:0]           dur, t1;
  logic [4:0]           nph, ph1;
  logic [SLOT_AW-1:0]   sel;
  logic [3:0]           old_mode;

  assign rd = slot_t'(ram_rdata);

  lbps_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(NUM_SLOTS),
    .AW   (SLOT_AW)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    pidx_d     = pidx_q;
    rv_d       = 1'b0;
    op_d       = op_q;
    pin_d      = pin_q;
    mode_d     = mode_q;
    used_d     = used_q;
    running_d  = running_q;
    found_d    = found_q;
    fidx_d     = fidx_q;
    fmode_d    = fmode_q;
    free_d     = free_q;
    freeidx_d  = freeidx_q;
    pend_v_d   = pend_v_q;
    pend_pin_d = pend_pin_q;
    pend_lvl_d = pend_lvl_q;
    valid_d    = 1'b0;
    kind_d     = kind_q;
    opin_d     = opin_q;
    lvl_d      = lvl_q;
    rmode_d    = rmode_q;
    last_d     = last_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = pidx_q;
    ram_raddr  = idx_q;
    ram_wdata  = rd;
    new_v      = 1'b0;
    new_lvl    = 1'b0;
    new_pin    = rd.pin;
    dur        = pat_dur(rd.mode, rd.phase);
    t1         = rd.ticks + 7'd1;
    nph        = phase_count(rd.mode);
    ph1        = {1'b0, rd.phase} + 5'd1;
    sel        = found_q ? fidx_q : freeidx_q;
    old_mode   = found_q ? fmode_q : MODE_OFF;

    // slot data returning from the RAM
    if (rv_q) begin
      if (op_q == CMD_TICK) begin
        if (used_q[pidx_q]) begin
          if (rd.mode == MODE_ON || rd.mode == MODE_OFF) begin
            new_v   = 1'b1;
            new_lvl = (rd.mode == MODE_ON);
          end else begin
            ram_we = 1'b1;
            if (t1 < dur) begin
              ram_wdata.ticks = t1;
            end else if (nph == 5'd1) begin
              ram_wdata.ticks = dur;
              new_v   = 1'b1;
              new_lvl = 1'b0;
            end else begin
              if (ph1 >= nph) begin
                ph1 = 5'd0;
              end
              ram_wdata.ticks = 7'd0;
              ram_wdata.phase = ph1[3:0];
              new_v   = 1'b1;
              new_lvl = ~ph1[0];
            end
          end
        end
      end else begin
        if (used_q[pidx_q] && rd.pin == pin_q && !found_q) begin
          found_d = 1'b1;
          fidx_d  = pidx_q;
          fmode_d = rd.mode;
        end
        if (!used_q[pidx_q]) begin
          free_d    = 1'b1;
          freeidx_d = pidx_q;
        end
      end
    end

    // hold one drive write back so the final one can carry last
    if (new_v) begin
      if (pend_v_q) begin
        valid_d = 1'b1;
        kind_d  = 1'b0;
        opin_d  = pend_pin_q;
        lvl_d   = pend_lvl_q;
        rmode_d = 4'd0;
        last_d  = 1'b0;
      end
      pend_v_d   = 1'b1;
      pend_pin_d = new_pin;
      pend_lvl_d = new_lvl;
    end

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          op_d      = cmd_i;
          pin_d     = pin_id_i;
          mode_d    = new_mode_i;
          idx_d     = '0;
          found_d   = 1'b0;
          free_d    = 1'b0;
          pend_v_d  = 1'b0;
          case (cmd_i)
            CMD_TICK:   if (running_q) state_d = ST_READ;
            CMD_SET:    if (new_mode_i < NUM_MODES) state_d = ST_READ;
            CMD_QUERY:  state_d = ST_READ;
            CMD_PAUSE:  running_d = 1'b0;
            CMD_RESUME: running_d = 1'b1;
            default:    ;
          endcase
        end
      end
      ST_READ: begin
        ram_re = 1'b1;
        rv_d   = 1'b1;
        pidx_d = idx_q;
        if (idx_q == SLOT_AW'(NUM_SLOTS - 1)) begin
          state_d = ST_LAST;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_LAST: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
        case (op_q)
          CMD_TICK: begin
            if (pend_v_q) begin
              valid_d  = 1'b1;
              kind_d   = 1'b0;
              opin_d   = pend_pin_q;
              lvl_d    = pend_lvl_q;
              rmode_d  = 4'd0;
              last_d   = 1'b1;
              pend_v_d = 1'b0;
            end
          end
          CMD_SET: begin
            if (found_q || free_q) begin
              used_d[sel] = 1'b1;
              if (mode_q != old_mode || pat_len(mode_q) == 4'd1) begin
                ram_we    = 1'b1;
                ram_waddr = sel;
                ram_wdata = '{pin: pin_q, mode: mode_q, phase: 4'd0, ticks: 7'd0};
                valid_d   = 1'b1;
                kind_d    = 1'b0;
                opin_d    = pin_q;
                lvl_d     = (mode_q != MODE_OFF);
                rmode_d   = 4'd0;
                last_d    = 1'b1;
              end
            end
          end
          CMD_QUERY: begin
            valid_d = 1'b1;
            kind_d  = 1'b1;
            opin_d  = pin_q;
            lvl_d   = 1'b0;
            rmode_d = found_q ? fmode_q : NO_MODE;
            last_d  = 1'b1;
          end
          default: ;
        endcase
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      rv_q      <= 1'b0;
      used_q    <= '0;
      running_q <= 1'b1;
      found_q   <= 1'b0;
      free_q    <= 1'b0;
      pend_v_q  <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      rv_q      <= rv_d;
      used_q    <= used_d;
      running_q <= running_d;
      found_q   <= found_d;
      free_q    <= free_d;
      pend_v_q  <= pend_v_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q     <= pidx_d;
    op_q       <= op_d;
    pin_q      <= pin_d;
    mode_q     <= mode_d;
    fidx_q     <= fidx_d;
    fmode_q    <= fmode_d;
    freeidx_q  <= freeidx_d;
    pend_pin_q <= pend_pin_d;
    pend_lvl_q <= pend_lvl_d;
    kind_q     <= kind_d;
    opin_q     <= opin_d;
    lvl_q      <= lvl_d;
    rmode_q    <= rmode_d;
    last_q     <= last_d;
  end

  assign busy            = (state_q != ST_IDLE);
  assign valid_o         = valid_q;
  assign kind_o          = kind_q;
  assign out_pin_o       = opin_q;
  assign level_o         = lvl_q;
  assign reported_mode_o = rmode_q;
  assign last_o          = last_q;

  `LBPS_ASSERT(a_report_is_last, (valid_o && kind_o) |-> last_o)
  `LBPS_ASSERT(a_result_from_walk, valid_o |-> ($past(state_q) != ST_IDLE))
  `LBPS_ASSERT_NEVER(a_no_rw_same_slot, ram_we && ram_re && (ram_waddr == ram_raddr))
  `LBPS_ASSERT(a_readback_busy, rv_q |-> (state_q == ST_READ || state_q == ST_LAST))

endmodule
